/* hdl/slmk_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sRGB to CIELAB package
// Shared widths, conversion constants and the sRGB linearization table.
// ----------------------------------------------------------------------------
package slmk_pkg;

	localparam int unsigned LIN_W = 17;
	localparam int unsigned SUM_W = 30;
	localparam int unsigned NUM_W = 37;
	localparam int unsigned Q_W = 21;
	localparam int unsigned Q10_W = 10;

	localparam int unsigned CDIV_LAT = 3;
	localparam int unsigned CBRT_STEPS = 21;
	localparam int unsigned CBRT_LAT = CBRT_STEPS;
	localparam int unsigned CBRT_REM_W = 48;
	localparam int unsigned CBRT_SHIFT = 40;

	localparam int unsigned M_XR = 4124;
	localparam int unsigned M_XG = 3576;
	localparam int unsigned M_XB = 1805;
	localparam int unsigned M_YR = 2126;
	localparam int unsigned M_YG = 7152;
	localparam int unsigned M_YB = 722;
	localparam int unsigned M_ZR = 193;
	localparam int unsigned M_ZG = 1192;
	localparam int unsigned M_ZB = 9505;

	localparam int unsigned DIV_X = 95047;
	localparam int unsigned DIV_Y = 10000;
	localparam int unsigned DIV_Z = 108883;
	localparam int unsigned RND_X = 47523;
	localparam int unsigned RND_Y = 5000;
	localparam int unsigned RND_Z = 54441;

	localparam int unsigned DIV_TOE = 116000;
	localparam longint unsigned TOE_MUL = 64'd903292;
	localparam longint unsigned TOE_ADD = (64'd16000 << 20) + 64'd58000;
	localparam longint unsigned TOE_MAX = (64'd8856 << 20) / 64'd1000000;

	localparam int unsigned L_OFS = 16 << 20;

	typedef logic [LIN_W-1:0] gamma_tab_t [256];

	function automatic gamma_tab_t gamma_table();
		gamma_tab_t tab;
		longint unsigned vv, t, tt, target, s, c;
		for (int v = 0; v < 256; v++) begin
			vv = 64'(v);
			if (vv <= 64'd10) begin
				tab[v] = LIN_W'((vv * 64'd6553600 + 64'd164730) / 64'd329460);
			end else begin
				t = (64'd65536 * (64'd1000 * vv + 64'd14025) + 64'd134512) / 64'd269025;
				tt = t * t;
				target = tt << 28;
				s = 64'd0;
				for (int b = 12; b >= 0; b--) begin
					c = s | (64'd1 << b);
					if (c <= 64'd4096) begin
						if (c * c * c * c * c <= target) begin
							s = c;
						end
					end
				end
				tab[v] = LIN_W'((tt * s + (64'd1 << 27)) >> 28);
			end
		end
		return tab;
	endfunction

	localparam gamma_tab_t GAMMA = gamma_table();

endpackage
`default_nettype wire

/* hdl/slmk_pix_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Pixel channel
// Valid/ready channel that carries one 8-bit sRGB pixel per transfer.
// ----------------------------------------------------------------------------
interface slmk_pix_if;
	logic valid;
	logic ready;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;

	modport source(output valid, red, green, blue, input ready);
	modport sink(input valid, red, green, blue, output ready);
endinterface
`default_nettype wire

/* hdl/slmk_lab_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// CIELAB result channel
// Valid/ready channel that carries L, a, b and the Morton key per transfer.
// ----------------------------------------------------------------------------
interface slmk_lab_if;
	logic valid;
	logic ready;
	logic [14:0] lightness;
	logic signed [15:0] green_red;
	logic signed [15:0] blue_yellow;
	logic [29:0] morton_key;

	modport source(output valid, lightness, green_red, blue_yellow, morton_key,
		input ready);
	modport sink(input valid, lightness, green_red, blue_yellow, morton_key,
		output ready);
endinterface
`default_nettype wire

/* hdl/slmk_cdiv.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Constant divider
// Three-stage floor division by a constant: reciprocal estimate, back
// multiplication, and a remainder correction of up to two.
// ----------------------------------------------------------------------------
module slmk_cdiv #(
	parameter int unsigned NW = 37,
	parameter int unsigned QW = 21,
	parameter int unsigned DIV = 95047
) (
	input logic clk,
	input logic en,
	input logic [NW-1:0] n,
	output logic [QW-1:0] q
);
	localparam int unsigned LO = $clog2(DIV) - 1;
	localparam int unsigned HW = NW - LO;
	localparam int unsigned K = NW + 3;
	localparam longint unsigned MC = (64'd1 << K) / DIV;
	localparam int unsigned MW = $clog2(MC + 1);
	localparam int unsigned DW = $clog2(DIV + 1);
	localparam int unsigned PW = HW + MW;
	localparam int unsigned XW = QW + DW;

	logic [PW-1:0] est;
	logic [QW-1:0] qe_s1, qe_s2, q_s3;
	logic [NW-1:0] n_s1, n_s2, rem;
	logic [XW-1:0] prod_s2;
	logic ge1, ge2;

	assign est = PW'(n[NW-1:LO]) * PW'(MC);

	always_ff @(posedge clk) begin
		if (en) begin
			qe_s1 <= QW'(est >> (K - LO));
			n_s1 <= n;
			qe_s2 <= qe_s1;
			n_s2 <= n_s1;
			prod_s2 <= XW'(qe_s1) * XW'(DIV);
			q_s3 <= qe_s2 + QW'(ge1) + QW'(ge2);
		end
	end

	always_comb begin
		rem = n_s2 - NW'(prod_s2);
		ge1 = rem >= NW'(DIV);
		ge2 = rem >= NW'(2 * DIV);
	end

	assign q = q_s3;
endmodule
`default_nettype wire

/* hdl/slmk_cbrt.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Cube root pipeline
// Digit-by-digit floor cube root of a Q20 ratio, one result bit per stage,
// carrying the root, its square and the partial remainder.
// ----------------------------------------------------------------------------
module slmk_cbrt (
	input logic clk,
	input logic en,
	input logic [slmk_pkg::Q_W-1:0] t,
	output logic [slmk_pkg::Q_W-1:0] root
);
	import slmk_pkg::*;

	localparam int unsigned N = CBRT_STEPS;
	localparam int unsigned TW = 3 * N;
	localparam int unsigned SQ_W = 2 * Q_W;
	localparam int unsigned RW = CBRT_REM_W;

	logic [Q_W-1:0] y_s [N];
	logic [SQ_W-1:0] y2_s [N-1];
	logic [RW-1:0] rem_s [N-1];
	logic [Q_W-1:0] t_s [N-1];

	for (genvar i = 0; i < N; i++) begin : g_step
		logic [Q_W-1:0] yi, ti;
		logic [SQ_W-1:0] y2i;
		logic [RW-1:0] remi, sh, trial;
		logic [TW-1:0] tgt;
		logic take;

		if (i == 0) begin : g_first
			assign yi = '0;
			assign y2i = '0;
			assign remi = '0;
			assign ti = t;
		end else begin : g_next
			assign yi = y_s[i-1];
			assign y2i = y2_s[i-1];
			assign remi = rem_s[i-1];
			assign ti = t_s[i-1];
		end

		always_comb begin
			tgt = TW'(ti) << CBRT_SHIFT;
			sh = {remi[RW-4:0], tgt[3*(N-1-i) +: 3]};
			trial = (RW'(y2i) << 3) + (RW'(y2i) << 2) + (RW'(yi) << 2)
				+ (RW'(yi) << 1) + RW'(1);
			take = sh >= trial;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				y_s[i] <= {yi[Q_W-2:0], take};
			end
		end

		if (i < N - 1) begin : g_carry
			always_ff @(posedge clk) begin
				if (en) begin
					y2_s[i] <= (y2i << 2) + (take ? ((SQ_W'(yi) << 2) + SQ_W'(1)) : '0);
					rem_s[i] <= take ? (sh - trial) : sh;
					t_s[i] <= ti;
				end
			end
		end
	end

	assign root = y_s[N-1];
endmodule
`default_nettype wire

/* hdl/slmk_xfer.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// CIELAB transfer function
// Cube root of a Q20 ratio, or the linear toe for small ratios, both paths
// aligned to the cube root latency.
// ----------------------------------------------------------------------------
module slmk_xfer (
	input logic clk,
	input logic en,
	input logic [slmk_pkg::Q_W-1:0] t,
	output logic [slmk_pkg::Q_W-1:0] f
);
	import slmk_pkg::*;

	localparam int unsigned TOE_DLY = CBRT_LAT - CDIV_LAT - 1;

	logic [Q_W-1:0] root, toe_q;
	logic [NUM_W-1:0] toe_n_s1;
	logic [Q_W-1:0] toe_s [TOE_DLY];
	logic [CBRT_LAT-1:0] sel_s;

	always_ff @(posedge clk) begin
		if (en) begin
			toe_n_s1 <= NUM_W'(64'(t) * TOE_MUL + TOE_ADD);
			sel_s <= {sel_s[CBRT_LAT-2:0], (t <= Q_W'(TOE_MAX))};
			toe_s[0] <= toe_q;
			for (int i = 1; i < TOE_DLY; i++) begin
				toe_s[i] <= toe_s[i-1];
			end
		end
	end

	slmk_cdiv #(
		.NW(NUM_W),
		.QW(Q_W),
		.DIV(DIV_TOE)
	) u_toe (
		.clk(clk),
		.en(en),
		.n(toe_n_s1),
		.q(toe_q)
	);

	slmk_cbrt u_cbrt (
		.clk(clk),
		.en(en),
		.t(t),
		.root(root)
	);

	assign f = sel_s[CBRT_LAT-1] ? toe_s[TOE_DLY-1] : root;
endmodule
`default_nettype wire

/* hdl/srgb_to_lab_morton_key.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sRGB to CIELAB converter with Morton key
// Converts 8-bit sRGB pixels to D65 CIELAB in fixed point and forms a
// 30-bit key from the interleaved 10-bit quantized L, a and b.
//
//   Channel  Role    Payload
//   pix      sink    red, green, blue (8 bits each)
//   lab      source  lightness, green_red, blue_yellow, morton_key
//
// One pixel enters per cycle while no result waits at the output. The
// 21-stage cube root makes up most of the pipeline.
// Reset clears only the valid bits of the pipeline.
// While a result waits at the output, the whole pipeline holds.
// ----------------------------------------------------------------------------
module srgb_to_lab_morton_key #(
	parameter int unsigned FRAC_BITS = 8
) (
	input logic clk,
	input logic arst_n,
	slmk_pix_if.sink pix,
	slmk_lab_if.source lab
);
	import slmk_pkg::*;

	localparam int unsigned SHIFT_Q = 20 - FRAC_BITS;
	localparam int unsigned ONE = 1 << FRAC_BITS;
	localparam int unsigned L_SPAN = 100 * ONE;
	localparam int unsigned AB_SH = 8 + FRAC_BITS;
	localparam int unsigned LAB_W = 33;
	localparam int unsigned VA_W = 10 + FRAC_BITS;
	localparam int unsigned QA_W = VA_W + 10;
	localparam int unsigned QL_NW = 34;
	localparam int unsigned LAT = 6 + 2 * CDIV_LAT + CBRT_LAT;

	localparam logic signed [LAB_W-1:0] L_MAX = LAB_W'(L_SPAN);
	localparam logic signed [LAB_W-1:0] AB_OFS = LAB_W'(128 * ONE);
	localparam logic signed [LAB_W-1:0] AB_MAX = LAB_W'(256 * ONE);
	localparam logic signed [LAB_W-1:0] SAT_HI = LAB_W'(32767);
	localparam logic signed [LAB_W-1:0] SAT_LO = -LAB_W'(32768);
	localparam logic [LAB_W-1:0] HALF = LAB_W'(1) << (SHIFT_Q - 1);

	typedef struct packed {
		logic [14:0] lightness;
		logic [15:0] green_red;
		logic [15:0] blue_yellow;
		logic [Q10_W-1:0] qa;
		logic [Q10_W-1:0] qb;
	} lab_mid_t;

	logic en;
	logic [LAT-1:0] vld_s;

	logic [LIN_W-1:0] r_s1, g_s1, b_s1;
	logic [SUM_W-1:0] x10_s2, y10_s2, z10_s2;
	logic [NUM_W-1:0] nx_s3, ny_s3, nz_s3;
	logic [Q_W-1:0] xq, yq, zq, fx, fy, fz;

	logic [LAB_W-1:0] l_raw, a_raw, b_raw;
	logic signed [LAB_W-1:0] lq_s, aq_s, bq_s;

	logic signed [LAB_W-1:0] lc, va, vb;
	logic [15:0] gr_sat, by_sat;
	logic [QA_W-1:0] qa_full, qb_full;
	lab_mid_t mid;
	lab_mid_t mid_s [CDIV_LAT+1];
	logic [QL_NW-1:0] nl_s;
	logic [Q10_W-1:0] ql;

	logic [29:0] key;
	logic [14:0] light_o;
	logic [15:0] gr_o, by_o;
	logic [29:0] key_o;

	assign en = !vld_s[LAT-1] || lab.ready;
	assign pix.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[LAT-2:0], pix.valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r_s1 <= GAMMA[pix.red];
			g_s1 <= GAMMA[pix.green];
			b_s1 <= GAMMA[pix.blue];
			x10_s2 <= SUM_W'(r_s1 * M_XR + g_s1 * M_XG + b_s1 * M_XB);
			y10_s2 <= SUM_W'(r_s1 * M_YR + g_s1 * M_YG + b_s1 * M_YB);
			z10_s2 <= SUM_W'(r_s1 * M_ZR + g_s1 * M_ZG + b_s1 * M_ZB);
			nx_s3 <= (NUM_W'(x10_s2) << 7) + (NUM_W'(x10_s2) << 5) + NUM_W'(RND_X);
			ny_s3 <= (NUM_W'(y10_s2) << 4) + NUM_W'(RND_Y);
			nz_s3 <= (NUM_W'(z10_s2) << 7) + (NUM_W'(z10_s2) << 5) + NUM_W'(RND_Z);
		end
	end

	slmk_cdiv #(.NW(NUM_W), .QW(Q_W), .DIV(DIV_X)) u_div_x (
		.clk(clk), .en(en), .n(nx_s3), .q(xq));
	slmk_cdiv #(.NW(NUM_W), .QW(Q_W), .DIV(DIV_Y)) u_div_y (
		.clk(clk), .en(en), .n(ny_s3), .q(yq));
	slmk_cdiv #(.NW(NUM_W), .QW(Q_W), .DIV(DIV_Z)) u_div_z (
		.clk(clk), .en(en), .n(nz_s3), .q(zq));

	slmk_xfer u_xfer_x (.clk(clk), .en(en), .t(xq), .f(fx));
	slmk_xfer u_xfer_y (.clk(clk), .en(en), .t(yq), .f(fy));
	slmk_xfer u_xfer_z (.clk(clk), .en(en), .t(zq), .f(fz));

	always_comb begin
		l_raw = LAB_W'(fy) * LAB_W'(116) - LAB_W'(L_OFS);
		a_raw = (LAB_W'(fx) - LAB_W'(fy)) * LAB_W'(500);
		b_raw = (LAB_W'(fy) - LAB_W'(fz)) * LAB_W'(200);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lq_s <= $signed(l_raw + HALF) >>> SHIFT_Q;
			aq_s <= $signed(a_raw + HALF) >>> SHIFT_Q;
			bq_s <= $signed(b_raw + HALF) >>> SHIFT_Q;
		end
	end

	always_comb begin
		lc = (lq_s < 0) ? '0 : ((lq_s > L_MAX) ? L_MAX : lq_s);
		gr_sat = (aq_s < SAT_LO) ? 16'h8000 : ((aq_s > SAT_HI) ? 16'h7FFF : aq_s[15:0]);
		by_sat = (bq_s < SAT_LO) ? 16'h8000 : ((bq_s > SAT_HI) ? 16'h7FFF : bq_s[15:0]);
		va = aq_s + AB_OFS;
		vb = bq_s + AB_OFS;
		va = (va < 0) ? '0 : ((va > AB_MAX) ? AB_MAX : va);
		vb = (vb < 0) ? '0 : ((vb > AB_MAX) ? AB_MAX : vb);
		qa_full = (QA_W'(va[VA_W-1:0]) * QA_W'(1023) + QA_W'(AB_OFS)) >> AB_SH;
		qb_full = (QA_W'(vb[VA_W-1:0]) * QA_W'(1023) + QA_W'(AB_OFS)) >> AB_SH;
		mid.lightness = lc[14:0];
		mid.green_red = gr_sat;
		mid.blue_yellow = by_sat;
		mid.qa = qa_full[Q10_W-1:0];
		mid.qb = qb_full[Q10_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nl_s <= QL_NW'(lc) * QL_NW'(1023) + QL_NW'(L_SPAN / 2);
			mid_s[0] <= mid;
			for (int i = 1; i <= CDIV_LAT; i++) begin
				mid_s[i] <= mid_s[i-1];
			end
		end
	end

	slmk_cdiv #(.NW(QL_NW), .QW(Q10_W), .DIV(L_SPAN)) u_div_l (
		.clk(clk), .en(en), .n(nl_s), .q(ql));

	always_comb begin
		for (int b = 0; b < Q10_W; b++) begin
			key[3*b+2] = ql[b];
			key[3*b+1] = mid_s[CDIV_LAT].qa[b];
			key[3*b] = mid_s[CDIV_LAT].qb[b];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			light_o <= mid_s[CDIV_LAT].lightness;
			gr_o <= mid_s[CDIV_LAT].green_red;
			by_o <= mid_s[CDIV_LAT].blue_yellow;
			key_o <= key;
		end
	end

	assign lab.valid = vld_s[LAT-1];
	assign lab.lightness = light_o;
	assign lab.green_red = $signed(gr_o);
	assign lab.blue_yellow = $signed(by_o);
	assign lab.morton_key = key_o;

`ifndef SYNTH
	a_gr_zero_key: assert property (@(posedge clk) disable iff (!arst_n)
		lab.valid && (lab.green_red == 16'sd0)
		|-> lab.morton_key[28] && !lab.morton_key[25])
		else $error("Zero a does not give the mid-scale a code in the key.");

	a_by_zero_key: assert property (@(posedge clk) disable iff (!arst_n)
		lab.valid && (lab.blue_yellow == 16'sd0)
		|-> lab.morton_key[27] && !lab.morton_key[24])
		else $error("Zero b does not give the mid-scale b code in the key.");

	a_dark_key: assert property (@(posedge clk) disable iff (!arst_n)
		lab.valid && (FRAC_BITS <= 7) && (lab.lightness == 15'd0)
		|-> !(lab.morton_key[29] || lab.morton_key[26] || lab.morton_key[23]
			|| lab.morton_key[20] || lab.morton_key[17] || lab.morton_key[14]
			|| lab.morton_key[11] || lab.morton_key[8] || lab.morton_key[5]
			|| lab.morton_key[2]))
		else $error("Zero lightness gives a nonzero L code in the key.");
`endif
endmodule
`default_nettype wire

/* dv/srgb_to_lab_morton_key_chk.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sRGB to CIELAB result checker
// Watches the pixel and result channels, computes the expected L, a, b and
// Morton key for every accepted pixel and compares them in order.
// ----------------------------------------------------------------------------
module srgb_to_lab_morton_key_chk #(
	parameter int unsigned FRAC_BITS = 8
) (
	input logic clk,
	input logic arst_n,
	slmk_pix_if pix,
	slmk_lab_if lab,
	output int errors,
	output int pending
);

	typedef struct packed {
		logic [14:0] lightness;
		logic signed [15:0] green_red;
		logic signed [15:0] blue_yellow;
		logic [29:0] morton_key;
	} lab_t;

	lab_t expected[int];
	int wr_count;
	int rd_count;

	function automatic longint unsigned linearize(logic [7:0] v);
		longint unsigned vv, t, tt, target, s, c;
		vv = 64'(v);
		if (vv <= 10) begin
			return (vv * 6553600 + 164730) / 329460;
		end
		t = (64'd65536 * (64'd1000 * vv + 64'd14025) + 64'd134512) / 64'd269025;
		tt = t * t;
		target = tt << 28;
		s = 0;
		for (int k = 12; k >= 0; k--) begin
			c = s | (64'd1 << k);
			if (c <= 4096 && c * c * c * c * c <= target) begin
				s = c;
			end
		end
		return (tt * s + (64'd1 << 27)) >> 28;
	endfunction

	function automatic longint lab_curve(longint unsigned t);
		longint unsigned target, r, c;
		if (t * 64'd1000000 > (64'd8856 << 20)) begin
			target = t << 40;
			r = 0;
			for (int k = 20; k >= 0; k--) begin
				c = r | (64'd1 << k);
				if (c * c * c <= target) begin
					r = c;
				end
			end
			return longint'(r);
		end
		return longint'((t * 7787 * 116 + (64'd16000 << 20) + 58000) / 116000);
	endfunction

	function automatic longint to_frac(longint v);
		longint unsigned u;
		u = longint'(v + (64'sd1 << 40)) + (64'd1 << (19 - FRAC_BITS));
		return longint'(u >> (20 - FRAC_BITS)) - ((64'sd1 << 40) >>> (20 - FRAC_BITS));
	endfunction

	function automatic longint clip(longint v, longint lo, longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	function automatic longint unsigned quantize(longint v, longint span);
		longint unsigned n;
		n = longint'(clip(v, 0, span));
		return (n * 1023 + longint'(span) / 2) / longint'(span);
	endfunction

	function automatic lab_t convert(logic [7:0] rv, logic [7:0] gv, logic [7:0] bv);
		longint unsigned r, g, b, xq, yq, zq, ql, qa, qb, key;
		longint fx, fy, fz, one, lq, aq, bq;
		lab_t res;
		r = linearize(rv);
		g = linearize(gv);
		b = linearize(bv);
		xq = ((4124 * r + 3576 * g + 1805 * b) * 160 + 47523) / 95047;
		yq = ((2126 * r + 7152 * g + 722 * b) * 16 + 5000) / 10000;
		zq = ((193 * r + 1192 * g + 9505 * b) * 160 + 54441) / 108883;
		fx = lab_curve(xq);
		fy = lab_curve(yq);
		fz = lab_curve(zq);
		one = 64'sd1 << FRAC_BITS;
		lq = to_frac(116 * fy - (64'sd16 << 20));
		aq = to_frac(500 * (fx - fy));
		bq = to_frac(200 * (fy - fz));
		ql = quantize(lq, 100 * one);
		qa = quantize(aq + 128 * one, 256 * one);
		qb = quantize(bq + 128 * one, 256 * one);
		key = 0;
		for (int k = 9; k >= 0; k--) begin
			key = (key << 3) | (((ql >> k) & 1) << 2) | (((qa >> k) & 1) << 1)
				| ((qb >> k) & 1);
		end
		res.lightness = 15'(clip(lq, 0, 100 * one));
		res.green_red = 16'(clip(aq, -32768, 32767));
		res.blue_yellow = 16'(clip(bq, -32768, 32767));
		res.morton_key = 30'(key);
		return res;
	endfunction

	task automatic report(string what, longint got, longint want);
		$display("%0t: %s got %0d expected %0d", $time, what, got, want);
		errors++;
	endtask

	initial begin
		errors = 0;
		pending = 0;
		wr_count = 0;
		rd_count = 0;
	end

	always @(posedge clk) begin
		lab_t want;
		if (arst_n) begin
			if (pix.valid && pix.ready) begin
				expected[wr_count] = convert(pix.red, pix.green, pix.blue);
				wr_count++;
			end
			if (lab.valid && lab.ready) begin
				if (wr_count == rd_count) begin
					report("unexpected result, key", lab.morton_key, 0);
				end else begin
					want = expected[rd_count];
					expected.delete(rd_count);
					rd_count++;
					if (lab.lightness !== want.lightness)
						report("lightness", lab.lightness, want.lightness);
					if (lab.green_red !== want.green_red)
						report("green_red", lab.green_red, want.green_red);
					if (lab.blue_yellow !== want.blue_yellow)
						report("blue_yellow", lab.blue_yellow, want.blue_yellow);
					if (lab.morton_key !== want.morton_key)
						report("morton_key", lab.morton_key, want.morton_key);
				end
			end
			pending = wr_count - rd_count;
		end
	end

endmodule

/* dv/srgb_to_lab_morton_key_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sRGB to CIELAB converter testbench
// Drives directed corner pixels and random pixels in bursts with a stalling
// receiver; the checker predicts each result and counts mismatches.
// ----------------------------------------------------------------------------
module srgb_to_lab_morton_key_tb;

	localparam int unsigned IDLE_LIMIT = 5000;
	localparam int unsigned RANDOM_PIXELS = 750;

	logic clk;
	logic arst_n;
	int errors;
	int pending;
	int idle_cycles;
	logic [23:0] corners[$];

	slmk_pix_if pix ();
	slmk_lab_if lab ();

	srgb_to_lab_morton_key dut (
		.clk(clk),
		.arst_n(arst_n),
		.pix(pix.sink),
		.lab(lab.source)
	);

	srgb_to_lab_morton_key_chk chk (
		.clk(clk),
		.arst_n(arst_n),
		.pix(pix),
		.lab(lab),
		.errors(errors),
		.pending(pending)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	task automatic send(logic [23:0] rgb);
		pix.valid <= 1;
		{pix.red, pix.green, pix.blue} <= rgb;
		do @(posedge clk); while (!pix.ready);
	endtask

	task automatic pause(int n);
		pix.valid <= 0;
		repeat (n) @(posedge clk);
	endtask

	initial begin
		int stall_mode;
		lab.ready = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			stall_mode = $urandom_range(0, 9);
			if (stall_mode < 3)
				lab.ready <= 1;
			else if (stall_mode < 8)
				lab.ready <= ($urandom_range(0, 3) != 0);
			else
				lab.ready <= 0;
		end
	end

	initial begin
		idle_cycles = 0;
		forever begin
			@(posedge clk);
			if ((pix.valid && pix.ready) || (lab.valid && lab.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("srgb_to_lab_morton_key: mismatch");
				$finish;
			end
		end
	end

	initial begin
		int sent;
		int burst;
		pix.valid = 0;
		pix.red = 0;
		pix.green = 0;
		pix.blue = 0;
		arst_n = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		corners = '{24'h000000, 24'hFFFFFF, 24'hFF0000, 24'h00FF00, 24'h0000FF,
			24'hFFFF00, 24'h00FFFF, 24'hFF00FF, 24'h0A0A0A, 24'h0B0B0B,
			24'h0A0B0C, 24'h010101, 24'h808080, 24'hAA5555, 24'h55AA55,
			24'h5555AA, 24'h0000FE, 24'hFE00FE, 24'h00FF01, 24'h7F7F7F};
		foreach (corners[i]) send(corners[i]);
		pause(1);
		wait (pending == 0);
		@(posedge clk);
		sent = 0;
		while (sent < RANDOM_PIXELS) begin
			burst = $urandom_range(1, 40);
			repeat (burst) begin
				case ($urandom_range(0, 5))
					0: send({8'($urandom_range(0, 12)), 8'($urandom_range(0, 12)),
						8'($urandom_range(0, 12))});
					1: send({8'($urandom_range(0, 1) * 255), 8'($urandom_range(0, 1) * 255),
						8'($urandom_range(0, 1) * 255)});
					default: send(24'($urandom));
				endcase
				sent++;
			end
			if ($urandom_range(0, 2) != 0)
				pause($urandom_range(1, 12));
		end
		pause(1);
		wait (pending == 0);
		repeat (60) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("srgb_to_lab_morton_key: match");
		else
			$display("srgb_to_lab_morton_key: mismatch");
		$finish;
	end

endmodule

/* filelist.f */
hdl/slmk_pkg.sv
hdl/slmk_pix_if.sv
hdl/slmk_lab_if.sv
hdl/slmk_cdiv.sv
hdl/slmk_cbrt.sv
hdl/slmk_xfer.sv
hdl/srgb_to_lab_morton_key.sv
dv/srgb_to_lab_morton_key_chk.sv
dv/srgb_to_lab_morton_key_tb.sv
